>>> hdl/b2d_pkg.sv
`timescale 1ns / 1ps

package b2d_pkg;

   localparam int VALUE_W   = 32;
   localparam int DIGITS    = 10;
   localparam int BCD_W     = 4 * DIGITS;
   localparam int CHAR_W    = 6;
   localparam int COUNT_W   = 4;
   localparam int BITCNT_W  = 5;
   localparam int STEP_W    = 2;

   localparam logic [CHAR_W-1:0]   ASCII_ZERO   = 6'd48;
   localparam logic [COUNT_W-1:0]  DIGITS_MAX   = 4'd10;
   localparam logic [BITCNT_W-1:0] BITS_LAST    = 5'd31;
   localparam logic [3:0]          DABBLE_LIMIT = 4'd5;
   localparam logic [3:0]          DABBLE_ADD   = 4'd3;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_WAIT = 2'd0;
   localparam step_type STEP_CONV = 2'd1;
   localparam step_type STEP_TRIM = 2'd2;
   localparam step_type STEP_EMIT = 2'd3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_SHIFT,
      OP_TRIM,
      OP_EMIT
   } op_type;

   // jump taken when the condition holds, else fall through to the next step
   typedef enum logic [1:0] {
      COND_NO_REQ,
      COND_BITS_LEFT,
      COND_LEAD_ZERO,
      COND_MORE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_word_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic drop_digit;
   } dp_ctl_type;

   typedef struct packed {
      logic [3:0] top_digit;
      logic       top_zero;
   } dp_stat_type;

   function automatic ucode_word_type ucode_rom(input step_type addr);
      ucode_word_type w;
      case (addr)
         STEP_WAIT: w = '{op: OP_LOAD,  cond: COND_NO_REQ,    target: STEP_WAIT};
         STEP_CONV: w = '{op: OP_SHIFT, cond: COND_BITS_LEFT, target: STEP_CONV};
         STEP_TRIM: w = '{op: OP_TRIM,  cond: COND_LEAD_ZERO, target: STEP_TRIM};
         STEP_EMIT: w = '{op: OP_EMIT,  cond: COND_MORE,      target: STEP_EMIT};
         default:   w = '{op: OP_LOAD,  cond: COND_NO_REQ,    target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

>>> hdl/b2d_if.sv
`timescale 1ns / 1ps

interface b2d_req_if
   import b2d_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2d_rsp_if
   import b2d_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  digit_char;
   logic [COUNT_W-1:0] digit_count;
   logic               last_digit;

   modport source (output valid, output digit_char, output digit_count,
                   output last_digit, input ready);
   modport sink   (input valid, input digit_char, input digit_count,
                   input last_digit, output ready);
endinterface

>>> hdl/b2d_bcd.sv
`timescale 1ns / 1ps

module b2d_bcd
   import b2d_pkg::*;
(
   input  logic               clock,
   input  dp_ctl_type         ctl,
   input  logic [VALUE_W-1:0] value,
   output dp_stat_type        stat
);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= DABBLE_LIMIT) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + DABBLE_ADD;
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctl.load) begin
         bin_in = value;
         bcd_in = '0;
      end else if (ctl.shift) begin
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
      end else if (ctl.drop_digit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.top_digit = bcd_ff[BCD_W-1 -: 4];
   assign stat.top_zero  = (bcd_ff[BCD_W-1 -: 4] == 4'd0);

endmodule

>>> hdl/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Channel   Dir  Words per value  Payload
// req_chan  in   1                value[31:0]
// rsp_chan  out  1 to 10          digit_char[5:0], digit_count[3:0], last_digit
//
// A value passes through a load step, one pass of the shift-add-3 unit per
// input bit, trim steps that drop leading zeros and one emit step per digit.
// Synchronous active-high reset returns the step counter to wait and empties
// the output register. A stalled rsp_chan holds the emit step in place.

module binary_to_decimal_ascii
   import b2d_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   b2d_req_if.sink   req_chan,
   b2d_rsp_if.source rsp_chan
);

   step_type            step_ff, step_in;
   logic [BITCNT_W-1:0] bits_ff, bits_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                last_ff, last_in;

   ucode_word_type      cw;
   dp_ctl_type          dp_ctl;
   dp_stat_type         dp_stat;
   logic                cond;
   logic                accept;
   logic                lead_zero;
   logic                emit_fire;

   assign cw        = ucode_rom(step_ff);
   assign accept    = req_chan.valid && (cw.op == OP_LOAD);
   assign lead_zero = dp_stat.top_zero && (rem_ff != 4'd1);
   assign emit_fire = (cw.op == OP_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   // condition select and next step
   always_comb begin
      case (cw.cond)
         COND_NO_REQ:    cond = !req_chan.valid;
         COND_BITS_LEFT: cond = (bits_ff != '0);
         COND_LEAD_ZERO: cond = lead_zero;
         COND_MORE:      cond = !(emit_fire && (rem_ff == 4'd1));
         default:        cond = 1'b0;
      endcase
      step_in = cond ? cw.target : step_ff + 2'd1;
   end

   // datapath control from the current control word
   always_comb begin
      dp_ctl.load       = accept;
      dp_ctl.shift      = (cw.op == OP_SHIFT);
      dp_ctl.drop_digit = ((cw.op == OP_TRIM) && lead_zero) || emit_fire;
   end

   always_comb begin
      bits_in = bits_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         bits_in = BITS_LAST;
         rem_in  = DIGITS_MAX;
         cnt_in  = DIGITS_MAX;
      end else if (cw.op == OP_SHIFT) begin
         bits_in = bits_ff - 5'd1;
      end else if ((cw.op == OP_TRIM) && lead_zero) begin
         rem_in = rem_ff - 4'd1;
         cnt_in = cnt_ff - 4'd1;
      end else if (emit_fire) begin
         rem_in = rem_ff - 4'd1;
      end
   end

   // output register: load on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         char_in      = ASCII_ZERO + {2'b00, dp_stat.top_digit};
         count_in     = cnt_ff;
         last_in      = (rem_ff == 4'd1);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      char_ff  <= char_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   b2d_bcd u_bcd (
      .clock (clock),
      .ctl   (dp_ctl),
      .value (req_chan.value),
      .stat  (dp_stat)
   );

   assign req_chan.ready       = (cw.op == OP_LOAD);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digit_char  = char_ff;
   assign rsp_chan.digit_count = count_ff;
   assign rsp_chan.last_digit  = last_ff;

`ifndef SYNTHESIS
   a_load_starts_conv: assert property (@(posedge clock) disable iff (reset)
      accept |=> (step_ff == STEP_CONV) && (bits_ff == BITS_LAST))
      else $error("accepted word did not start the conversion loop");

   a_trim_counts_agree: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_TRIM) |-> (rem_ff == cnt_ff))
      else $error("digit counters diverged during trim");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && (rem_ff == 4'd1)) |=> rsp_valid_ff && last_ff && (step_ff == STEP_WAIT))
      else $error("final digit not flagged or sequencer not back to wait");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (count_ff != 4'd0) && (count_ff <= DIGITS_MAX))
      else $error("digit count out of range");

   a_emit_nonzero_rem: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_EMIT) |-> (rem_ff != 4'd0))
      else $error("emit step with no digits left");
`endif

endmodule
